// File: hdl/rjd_pkg.sv
package rjd_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned StepW  = 31;
    localparam int unsigned LayerW = 8;

    typedef enum logic [1:0] {
        JOG_CW   = 2'd0,
        JOG_CCW  = 2'd1,
        JOG_NONE = 2'd2
    } t_jog_kind;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic                     ring_start;
        logic        [LayerW-1:0] layer_index;
    } t_in_word;

    typedef struct packed {
        logic signed [CoordW-1:0] box_x_low;
        logic signed [CoordW-1:0] box_y_low;
        logic signed [CoordW-1:0] box_x_high;
        logic signed [CoordW-1:0] box_y_high;
        t_jog_kind                jog_kind;
        logic        [LayerW-1:0] layer_out;
    } t_out_word;

    // Three consecutive ring vertices plus the layer of the newest one.
    typedef struct packed {
        logic signed [CoordW-1:0] x0;
        logic signed [CoordW-1:0] y0;
        logic signed [CoordW-1:0] x1;
        logic signed [CoordW-1:0] y1;
        logic signed [CoordW-1:0] x2;
        logic signed [CoordW-1:0] y2;
        logic        [LayerW-1:0] layer;
    } t_jog_pts;

endpackage

// File: hdl/rectilinear_jog_detector_core.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_word  (t_in_word)
// output    out        o_out_valid / i_out_stall o_out_word (t_out_word)
// config    in         i_cfg_we                  i_cfg_data (min_step)
//
// One vertex word is accepted per cycle while o_in_stall is low; its result word is registered.
// The vertex history advances at acceptance; the jog test runs between the
// vertex register and the result register.
// Reset clears the history, the vertex count, min_step and both valid flags.
// A stalled result holds the vertex register only when that vertex also makes a result.
module rectilinear_jog_detector_core
    import rjd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [StepW-1:0] i_cfg_data
);

    logic [StepW-1:0]         r_min_step;
    logic signed [CoordW-1:0] r_older_x, r_older_y, r_prev_x, r_prev_y;
    logic [1:0]               r_points_seen, n_points_seen, seen_base;
    logic                     r_s1_valid, n_s1_valid;
    logic                     r_s1_elig;
    t_jog_pts                 r_s1_pts;
    logic                     r_out_valid, n_out_valid;
    t_out_word                r_out_word;
    logic                     in_acc, out_free, s1_hit, s1_move, s1_res;
    logic                     eval_hit;
    t_out_word                eval_word;

    rjd_jog_eval u_eval (
        .i_pts      (r_s1_pts),
        .i_min_step (r_min_step),
        .o_hit      (eval_hit),
        .o_word     (eval_word)
    );

    assign s1_hit   = r_s1_elig && eval_hit;
    assign s1_res   = r_s1_valid && s1_hit;
    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_move  = !s1_res || out_free;
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_acc   = i_in_valid && !o_in_stall;

    assign seen_base     = i_in_word.ring_start ? 2'd0 : r_points_seen;
    assign n_points_seen = (seen_base == 2'd2) ? 2'd2 : seen_base + 2'd1;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_move) begin
            n_s1_valid = in_acc;
        end
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step    <= '0;
            r_older_x     <= '0;
            r_older_y     <= '0;
            r_prev_x      <= '0;
            r_prev_y      <= '0;
            r_points_seen <= '0;
            r_s1_valid    <= 1'b0;
            r_s1_elig     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_step <= i_cfg_data;
            end
            if (in_acc) begin
                r_older_x     <= r_prev_x;
                r_older_y     <= r_prev_y;
                r_prev_x      <= i_in_word.point_x;
                r_prev_y      <= i_in_word.point_y;
                r_points_seen <= n_points_seen;
                r_s1_elig     <= (seen_base == 2'd2);
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pts.x0    <= r_older_x;
            r_s1_pts.y0    <= r_older_y;
            r_s1_pts.x1    <= r_prev_x;
            r_s1_pts.y1    <= r_prev_y;
            r_s1_pts.x2    <= i_in_word.point_x;
            r_s1_pts.y2    <= i_in_word.point_y;
            r_s1_pts.layer <= i_in_word.layer_index;
        end
        if (out_free && s1_res) begin
            r_out_word <= eval_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_points_seen != 2'd3)
        else $error("vertex count left its range");

    a_start_no_jog : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.ring_start) |=> !r_s1_elig)
        else $error("ring start vertex marked as jog candidate");

    a_zero_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_min_step == '0) |-> !s1_hit)
        else $error("jog found with zero min_step");

    a_out_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s1_res))
        else $error("result word without a jog vertex");

    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_res && !s1_move) |=> (r_s1_valid && $stable(r_s1_pts)))
        else $error("pending jog vertex lost under stall");

endmodule

// File: hdl/rjd_jog_eval.sv
module rjd_jog_eval
    import rjd_pkg::*;
(
    input  t_jog_pts         i_pts,
    input  logic [StepW-1:0] i_min_step,
    output logic             o_hit,
    output t_out_word        o_word
);

    logic signed [CoordW:0]   ax, ay, bx, by;
    logic        [CoordW:0]   abs_ax, abs_ay, abs_bx, abs_by;
    logic        [CoordW+1:0] len_a, len_b, step_ext;
    logic                     ax_p, ax_n, ax_z, ay_p, ay_n, ay_z;
    logic                     bx_p, bx_n, bx_z, by_p, by_n, by_z;
    logic                     cw, ccw;
    logic signed [CoordW-1:0] xmin01, ymin01, xmax01, ymax01;

    // Differences are one bit wider than the coordinates so they never wrap.
    assign ax = {i_pts.x1[CoordW-1], i_pts.x1} - {i_pts.x0[CoordW-1], i_pts.x0};
    assign ay = {i_pts.y1[CoordW-1], i_pts.y1} - {i_pts.y0[CoordW-1], i_pts.y0};
    assign bx = {i_pts.x2[CoordW-1], i_pts.x2} - {i_pts.x1[CoordW-1], i_pts.x1};
    assign by = {i_pts.y2[CoordW-1], i_pts.y2} - {i_pts.y1[CoordW-1], i_pts.y1};

    assign abs_ax = ax[CoordW] ? -ax : ax;
    assign abs_ay = ay[CoordW] ? -ay : ay;
    assign abs_bx = bx[CoordW] ? -bx : bx;
    assign abs_by = by[CoordW] ? -by : by;

    assign len_a    = {1'b0, abs_ax} + {1'b0, abs_ay};
    assign len_b    = {1'b0, abs_bx} + {1'b0, abs_by};
    assign step_ext = {{(CoordW+2-StepW){1'b0}}, i_min_step};

    assign o_hit = (len_a < step_ext) && (len_b < step_ext);

    assign ax_z = (ax == '0);
    assign ay_z = (ay == '0);
    assign bx_z = (bx == '0);
    assign by_z = (by == '0);
    assign ax_n = ax[CoordW];
    assign ay_n = ay[CoordW];
    assign bx_n = bx[CoordW];
    assign by_n = by[CoordW];
    assign ax_p = !ax_n && !ax_z;
    assign ay_p = !ay_n && !ay_z;
    assign bx_p = !bx_n && !bx_z;
    assign by_p = !by_n && !by_z;

    assign cw  = (ax_p && ay_z && bx_z && by_n) || (ax_z && ay_n && bx_n && by_z) ||
                 (ax_n && ay_z && bx_z && by_p) || (ax_z && ay_p && bx_p && by_z);
    assign ccw = (ax_z && ay_n && bx_p && by_z) || (ax_p && ay_z && bx_z && by_p) ||
                 (ax_z && ay_p && bx_n && by_z) || (ax_n && ay_z && bx_z && by_n);

    assign xmin01 = (i_pts.x0 < i_pts.x1) ? i_pts.x0 : i_pts.x1;
    assign ymin01 = (i_pts.y0 < i_pts.y1) ? i_pts.y0 : i_pts.y1;
    assign xmax01 = (i_pts.x0 > i_pts.x1) ? i_pts.x0 : i_pts.x1;
    assign ymax01 = (i_pts.y0 > i_pts.y1) ? i_pts.y0 : i_pts.y1;

    always_comb begin
        o_word.box_x_low  = (xmin01 < i_pts.x2) ? xmin01 : i_pts.x2;
        o_word.box_y_low  = (ymin01 < i_pts.y2) ? ymin01 : i_pts.y2;
        o_word.box_x_high = (xmax01 > i_pts.x2) ? xmax01 : i_pts.x2;
        o_word.box_y_high = (ymax01 > i_pts.y2) ? ymax01 : i_pts.y2;
        if (cw) begin
            o_word.jog_kind = JOG_CW;
        end else if (ccw) begin
            o_word.jog_kind = JOG_CCW;
        end else begin
            o_word.jog_kind = JOG_NONE;
        end
        o_word.layer_out = i_pts.layer;
    end

endmodule

// File: sim/rectilinear_jog_detector_core_tb.sv
module rectilinear_jog_detector_core_tb;
    import rjd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_WORDS   = 120;
    localparam int RANDOM_PHASES = 7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_in_word         in_word = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_word        out_word;
    logic             cfg_we = 1'b0;
    logic [StepW-1:0] cfg_data = '0;

    // Predictor copy of the vertex history and the register.
    logic signed [CoordW-1:0] hist_older_x = '0;
    logic signed [CoordW-1:0] hist_older_y = '0;
    logic signed [CoordW-1:0] hist_prev_x = '0;
    logic signed [CoordW-1:0] hist_prev_y = '0;
    int unsigned              ring_pts = 0;
    logic [StepW-1:0]         min_step = '0;

    t_in_word  vertex_queue[$];
    t_out_word jog_expect[$];
    int        words_pending = 0;
    int        words_accepted = 0;
    int        rings_started = 0;
    int        jogs_checked = 0;
    int        kind_count[3] = '{0, 0, 0};
    int        mismatch_count = 0;
    int        settings_used = 0;
    int        cycle_count = 0;
    bit        steady = 1'b0;

    // Random ring walk.
    logic signed [CoordW-1:0] walk_x = '0;
    logic signed [CoordW-1:0] walk_y = '0;
    logic                     walk_on_x = 1'b0;
    logic [LayerW-1:0]        walk_layer = '0;

    rectilinear_jog_detector_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint lowest3(longint a, longint b, longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint highest3(longint a, longint b, longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic t_jog_kind turn_kind(longint ax, longint ay, longint bx, longint by);
        if ((ax > 0 && ay == 0 && bx == 0 && by < 0) ||
            (ax == 0 && ay < 0 && bx < 0 && by == 0) ||
            (ax < 0 && ay == 0 && bx == 0 && by > 0) ||
            (ax == 0 && ay > 0 && bx > 0 && by == 0)) begin
            return JOG_CW;
        end
        if ((ax == 0 && ay < 0 && bx > 0 && by == 0) ||
            (ax > 0 && ay == 0 && bx == 0 && by > 0) ||
            (ax == 0 && ay > 0 && bx < 0 && by == 0) ||
            (ax < 0 && ay == 0 && bx == 0 && by < 0)) begin
            return JOG_CCW;
        end
        return JOG_NONE;
    endfunction

    // Advances the history by one accepted vertex and queues the jog it makes, if any.
    task automatic predict_jog(input t_in_word w);
        longint    x0, y0, x1, y1, x2, y2, ax, ay, bx, by;
        t_out_word jog;
        if (w.ring_start) begin
            ring_pts = 0;
            rings_started++;
        end
        if (ring_pts >= 2) begin
            x0 = hist_older_x;
            y0 = hist_older_y;
            x1 = hist_prev_x;
            y1 = hist_prev_y;
            x2 = w.point_x;
            y2 = w.point_y;
            ax = x1 - x0;
            ay = y1 - y0;
            bx = x2 - x1;
            by = y2 - y1;
            if (magnitude(ax) + magnitude(ay) < longint'(min_step) &&
                magnitude(bx) + magnitude(by) < longint'(min_step)) begin
                jog.box_x_low  = CoordW'(lowest3(x0, x1, x2));
                jog.box_y_low  = CoordW'(lowest3(y0, y1, y2));
                jog.box_x_high = CoordW'(highest3(x0, x1, x2));
                jog.box_y_high = CoordW'(highest3(y0, y1, y2));
                jog.jog_kind   = turn_kind(ax, ay, bx, by);
                jog.layer_out  = w.layer_index;
                jog_expect.push_back(jog);
            end
        end
        hist_older_x = hist_prev_x;
        hist_older_y = hist_prev_y;
        hist_prev_x  = w.point_x;
        hist_prev_y  = w.point_y;
        if (ring_pts < 2) ring_pts++;
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("[%0d] mismatch: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [CoordW-1:0] got,
                               input logic [CoordW-1:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s expected %h, got %h", name, want, got));
        end
    endtask

    // Input side: one word per handshake, random gaps unless steady, prediction at acceptance.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_jog(in_word);
                words_pending--;
                words_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (vertex_queue.size() > 0 && (steady || $urandom_range(99) >= 17)) begin
                    in_word  <= vertex_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls unless steady, each accepted word checked against the oldest expectation.
    always @(posedge clk) begin
        t_out_word want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (jog_expect.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result word %h", out_word));
                end else begin
                    want = jog_expect.pop_front();
                    check_field("box_x_low", out_word.box_x_low, want.box_x_low);
                    check_field("box_y_low", out_word.box_y_low, want.box_y_low);
                    check_field("box_x_high", out_word.box_x_high, want.box_x_high);
                    check_field("box_y_high", out_word.box_y_high, want.box_y_high);
                    check_field("jog_kind", CoordW'(out_word.jog_kind), CoordW'(want.jog_kind));
                    check_field("layer_out", CoordW'(out_word.layer_out),
                                CoordW'(want.layer_out));
                    jogs_checked++;
                    kind_count[want.jog_kind]++;
                end
            end
            out_stall <= !steady && ($urandom_range(99) < 17);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("rectilinear_jog_detector_core_tb failed");
            $finish;
        end
    end

    task automatic push_vertex(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                               input logic start, input logic [LayerW-1:0] layer);
        t_in_word w;
        w.point_x     = x;
        w.point_y     = y;
        w.ring_start  = start;
        w.layer_index = layer;
        vertex_queue.push_back(w);
        words_pending++;
    endtask

    // Mostly rectilinear walks with edges around the threshold; some noise,
    // diagonals, repeated vertices and straight runs mixed in.
    task automatic push_random_vertex();
        int unsigned              pick;
        int unsigned              lim;
        logic signed [CoordW-1:0] len;
        logic                     start;
        pick  = $urandom_range(99);
        lim   = (min_step < 2) ? 3 : min_step;
        len   = ($urandom_range(4) == 0) ? $urandom_range(lim + 1, lim - 1)
                                         : $urandom_range(lim - 1, 1);
        start = 1'b0;
        if ($urandom_range(1)) len = -len;
        if (pick < 8) begin
            start      = 1'b1;
            walk_layer = LayerW'($urandom_range(255));
            case ($urandom_range(3))
                0: begin
                    walk_x = 32'h7FFF_FFFF - $urandom_range(2);
                    walk_y = 32'h8000_0000 + $urandom_range(2);
                end
                1: begin
                    walk_x = 32'h8000_0000 + $urandom_range(2);
                    walk_y = 32'h7FFF_FFFF - $urandom_range(2);
                end
                2: begin
                    walk_x = $urandom_range(2000) - 1000;
                    walk_y = $urandom_range(2000) - 1000;
                end
                default: begin
                    walk_x = $urandom;
                    walk_y = $urandom;
                end
            endcase
        end else if (pick < 13) begin
            walk_x     = $urandom;
            walk_y     = $urandom;
            walk_layer = LayerW'($urandom_range(255));
            start      = 1'($urandom_range(1));
        end else if (pick < 18) begin
            walk_x = walk_x + len;
            walk_y = $urandom_range(1) ? walk_y + len : walk_y - len;
        end else if (pick >= 23) begin
            // Below pick 30 the axis is kept, so the new edge runs on the same axis as the last walk step.
            if (pick >= 30) walk_on_x = !walk_on_x;
            if (walk_on_x) walk_x = walk_x + len;
            else walk_y = walk_y + len;
        end
        push_vertex(walk_x, walk_y, start, walk_layer);
    endtask

    // Returns only once all words are taken and every result has arrived.
    task automatic wait_idle();
        while (words_pending != 0 || jog_expect.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Called right after a rising edge with the block idle.
    task automatic write_min_step(input logic [StepW-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        min_step = value;
        settings_used++;
    endtask

    initial begin
        logic [StepW-1:0] step_value;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_min_step(StepW'(16));
        // Vertices before the first ring start still form a jog of their own.
        push_vertex(0, 0, 1'b0, 8'd0);
        push_vertex(5, 0, 1'b0, 8'd0);
        push_vertex(5, -5, 1'b0, 8'd3);
        // Clockwise square: every clockwise turn once.
        push_vertex(0, 0, 1'b1, 8'hFF);
        push_vertex(0, 4, 1'b0, 8'hFF);
        push_vertex(4, 4, 1'b0, 8'hFF);
        push_vertex(4, 0, 1'b0, 8'hFF);
        push_vertex(0, 0, 1'b0, 8'hFF);
        push_vertex(0, 4, 1'b0, 8'hFF);
        // Counter-clockwise square: every counter-clockwise turn once.
        push_vertex(0, 0, 1'b1, 8'hA5);
        push_vertex(4, 0, 1'b0, 8'hA5);
        push_vertex(4, 4, 1'b0, 8'hA5);
        push_vertex(0, 4, 1'b0, 8'hA5);
        push_vertex(0, 0, 1'b0, 8'hA5);
        push_vertex(4, 0, 1'b0, 8'h5A);
        // Jog at the corner of the coordinate range.
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 8'h81);
        push_vertex(32'h7FFF_FFFF, 32'h8000_000A, 1'b0, 8'h81);
        push_vertex(32'h7FFF_FFF5, 32'h8000_000A, 1'b0, 8'h7E);
        // Straight run, repeated vertex, diagonal, then an edge exactly min_step long.
        push_vertex(10, 10, 1'b1, 8'h42);
        push_vertex(13, 10, 1'b0, 8'h42);
        push_vertex(16, 10, 1'b0, 8'h42);
        push_vertex(16, 10, 1'b0, 8'h42);
        push_vertex(18, 12, 1'b0, 8'h42);
        push_vertex(18, 28, 1'b0, 8'h42);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: step_value = StepW'(1);
                1: step_value = StepW'(2);
                2: step_value = StepW'($urandom_range(40, 5));
                3: step_value = StepW'(0);
                4: step_value = 31'h7FFF_FFFF;
                5: step_value = StepW'($urandom_range(100000, 100));
                default: step_value = StepW'($urandom_range(20, 3));
            endcase
            write_min_step(step_value);
            steady = (p == 2);
            repeat (PHASE_WORDS) push_random_vertex();
            wait_idle();
        end
        steady = 1'b0;

        if (jog_expect.size() != 0) flag_mismatch("results still expected at the end");
        $display("%0d vertex words in %0d rings under %0d min_step settings (0, 1, max incl.)",
                 words_accepted, rings_started, settings_used);
        $display("%0d jogs checked: %0d convex, %0d concave, %0d neither; %0d mismatches",
                 jogs_checked, kind_count[JOG_CW], kind_count[JOG_CCW], kind_count[JOG_NONE],
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("rectilinear_jog_detector_core_tb passed");
        end else begin
            $display("rectilinear_jog_detector_core_tb failed");
        end
        $finish;
    end

endmodule
